// ===== src/nem_pkg.sv =====
// shared types and constants of the neighbour equality map
package nem_pkg;

  localparam int ROW_W      = 16;
  localparam int RES_COL_W  = 10;
  localparam int FCOLS_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_PIX_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd1;

  // results per pixel request at most, result buffer sizing (depth a power of two)
  localparam int RES_PER_ITEM = 4;
  localparam int RES_DEPTH    = 16;
  localparam int RES_PTR_W    = 4;
  localparam int RES_CNT_W    = RES_PTR_W + 1;
  localparam int TASK_DEPTH   = 4;

  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic last_col;
    logic last_row;
  } nem_flags_t;

  localparam int FLAGS_W = $bits(nem_flags_t);

  typedef struct packed {
    logic                 match_flag;
    logic [ROW_W-1:0]     row;
    logic [RES_COL_W-1:0] col;
    logic                 frame_done;
  } nem_result_t;

endpackage

// ===== src/nem_front.sv =====
// front end: frame geometry registers, input position counters and classification
module nem_front #(
  parameter int MAX_COLS = 1024,
  parameter int COL_W    = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  output logic [COL_W-1:0]               t_col,
  output logic [nem_pkg::ROW_W-1:0]      t_row,
  output nem_pkg::nem_flags_t            t_flags
);
  import nem_pkg::*;

  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // zero acts as one, too wide saturates
  function automatic logic [COL_W-1:0] cols_to_last(input logic [FCOLS_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > 32'(MAX_COLS)) begin
      r = COL_W'(MAX_COLS - 1);
    end else begin
      r = COL_W'(v - FCOLS_W'(1));
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= cols_to_last(FCOLS_W'(8));
      last_row <= ROW_W'(7);
      col      <= '0;
      row      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_COLS: begin
          last_col <= cols_to_last(cfg_data[FCOLS_W-1:0]);
          col      <= '0;
          row      <= '0;
        end
        CFG_FRAME_ROWS: begin
          last_row <= (cfg_data == '0) ? '0 : cfg_data - ROW_W'(1);
          col      <= '0;
          row      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  assign t_col = col;
  assign t_row = row;

  always_comb begin
    t_flags.row_ge1  = (row != '0);
    t_flags.row_ge2  = (row > ROW_W'(1));
    t_flags.col_ge1  = (col != '0);
    t_flags.col_ge2  = (col > COL_W'(1));
    t_flags.last_col = (col == last_col);
    t_flags.last_row = (row == last_row);
  end

endmodule

// ===== src/nem_fifo.sv =====
// small register queue between front and back end
module nem_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import nem_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/nem_back.sv =====
// back end: line store, 3x3 window and neighbour comparison
module nem_back #(
  parameter int PIX_W     = 32,
  parameter int COL_W     = 10,
  parameter int MEM_DEPTH = 1024
) (
  input  logic                                                        clk,
  input  logic                                                        rst,
  input  logic                                                        task_valid,
  input  logic [PIX_W+COL_W+nem_pkg::ROW_W+nem_pkg::FLAGS_W-1:0]     task_data,
  output logic                                                        task_take,
  input  logic [nem_pkg::RES_CNT_W-1:0]                               free_slots,
  output logic [nem_pkg::RES_PER_ITEM-1:0]                            res_mask,
  output nem_pkg::nem_result_t                                        res_ent [nem_pkg::RES_PER_ITEM]
);
  import nem_pkg::*;

  localparam logic [RES_CNT_W-1:0] RPI = RES_CNT_W'(RES_PER_ITEM);

  logic [PIX_W-1:0]   t_pix;
  logic [COL_W-1:0]   t_col;
  logic [ROW_W-1:0]   t_row;
  nem_flags_t         t_flags;

  // two stored rows per column: older row in the high half, upper row in the low half
  logic [2*PIX_W-1:0] line_store [MEM_DEPTH];
  logic [2*PIX_W-1:0] rd_q;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  nem_flags_t         s1_flags;
  logic               s1_fwd;
  logic [PIX_W-1:0]   s1_fwd_older;
  logic [PIX_W-1:0]   s1_fwd_upper;
  logic [PIX_W-1:0]   older_eff;
  logic [PIX_W-1:0]   upper_eff;

  logic               s2_valid;
  logic [COL_W-1:0]   s2_col;
  logic [ROW_W-1:0]   s2_row;
  nem_flags_t         s2_flags;

  logic [PIX_W-1:0]   win [3][3];
  logic [RES_CNT_W-1:0] need;

  function automatic logic same(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return a == b;
  endfunction

  assign {t_pix, t_col, t_row, t_flags} = task_data;

  // room for every result of the items already in flight plus this one
  always_comb begin
    need = RPI;
    if (s1_valid) begin
      need = need + RPI;
    end
    if (s2_valid) begin
      need = need + RPI;
    end
  end

  assign task_take = task_valid && (free_slots >= need);

  // one-column frames read the column the previous pixel writes at the same edge
  assign older_eff = s1_fwd ? s1_fwd_older : rd_q[2*PIX_W-1:PIX_W];
  assign upper_eff = s1_fwd ? s1_fwd_upper : rd_q[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (task_take) begin
      rd_q <= line_store[t_col];
    end
    if (s1_valid) begin
      line_store[s1_col] <= {upper_eff, s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= task_take;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (task_take) begin
      s1_pix       <= t_pix;
      s1_col       <= t_col;
      s1_row       <= t_row;
      s1_flags     <= t_flags;
      s1_fwd       <= s1_valid && (s1_col == t_col);
      s1_fwd_older <= upper_eff;
      s1_fwd_upper <= s1_pix;
    end
    if (s1_valid) begin
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_flags <= s1_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= older_eff;
      win[1][2] <= upper_eff;
      win[2][2] <= s1_pix;
    end
  end

  // candidates in raster order: upper-left, upper, left, current
  always_comb begin
    logic r1;
    logic r2;
    logic c1;
    logic c2;
    r1 = s2_flags.row_ge1;
    r2 = s2_flags.row_ge2;
    c1 = s2_flags.col_ge1;
    c2 = s2_flags.col_ge2;

    res_mask[0] = s2_valid && r1 && c1;
    res_mask[1] = s2_valid && r1 && s2_flags.last_col;
    res_mask[2] = s2_valid && s2_flags.last_row && c1;
    res_mask[3] = s2_valid && s2_flags.last_row && s2_flags.last_col;

    res_ent[0].match_flag = (same(win[0][0], win[1][1]) && r2 && c2)
                          | (same(win[0][1], win[1][1]) && r2)
                          | (same(win[0][2], win[1][1]) && r2)
                          | (same(win[1][0], win[1][1]) && c2)
                          |  same(win[1][2], win[1][1])
                          | (same(win[2][0], win[1][1]) && c2)
                          |  same(win[2][1], win[1][1])
                          |  same(win[2][2], win[1][1]);
    res_ent[0].row        = s2_row - ROW_W'(1);
    res_ent[0].col        = RES_COL_W'(s2_col - COL_W'(1));
    res_ent[0].frame_done = 1'b0;

    res_ent[1].match_flag = (same(win[0][1], win[1][2]) && r2 && c1)
                          | (same(win[0][2], win[1][2]) && r2)
                          | (same(win[1][1], win[1][2]) && c1)
                          | (same(win[2][1], win[1][2]) && c1)
                          |  same(win[2][2], win[1][2]);
    res_ent[1].row        = s2_row - ROW_W'(1);
    res_ent[1].col        = RES_COL_W'(s2_col);
    res_ent[1].frame_done = 1'b0;

    res_ent[2].match_flag = (same(win[1][0], win[2][1]) && r1 && c2)
                          | (same(win[1][1], win[2][1]) && r1)
                          | (same(win[1][2], win[2][1]) && r1)
                          | (same(win[2][0], win[2][1]) && c2)
                          |  same(win[2][2], win[2][1]);
    res_ent[2].row        = s2_row;
    res_ent[2].col        = RES_COL_W'(s2_col - COL_W'(1));
    res_ent[2].frame_done = 1'b0;

    res_ent[3].match_flag = (same(win[1][1], win[2][2]) && r1 && c1)
                          | (same(win[1][2], win[2][2]) && r1)
                          | (same(win[2][1], win[2][2]) && c1);
    res_ent[3].row        = s2_row;
    res_ent[3].col        = RES_COL_W'(s2_col);
    res_ent[3].frame_done = 1'b1;
  end

endmodule

// ===== src/nem_result_buf.sv =====
// result buffer taking up to four results a cycle, handing out one
module nem_result_buf (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [nem_pkg::RES_PER_ITEM-1:0]  push_mask,
  input  nem_pkg::nem_result_t              push_ent [nem_pkg::RES_PER_ITEM],
  input  logic                              pop,
  output logic                              empty,
  output nem_pkg::nem_result_t              head,
  output logic [nem_pkg::RES_CNT_W-1:0]     free_slots
);
  import nem_pkg::*;

  nem_result_t          slots [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr;
  logic [RES_PTR_W-1:0] rptr;
  logic [RES_CNT_W-1:0] count;
  logic [RES_PTR_W-1:0] off [RES_PER_ITEM];
  logic [RES_CNT_W-1:0] n_push;
  logic                 do_pop;

  // packing offsets: each valid result lands after the valid ones before it
  always_comb begin
    off[0] = '0;
    for (int k = 1; k < RES_PER_ITEM; k++) begin
      off[k] = off[k-1] + RES_PTR_W'(push_mask[k-1]);
    end
    n_push = RES_CNT_W'(off[RES_PER_ITEM-1]) + RES_CNT_W'(push_mask[RES_PER_ITEM-1]);
  end

  assign empty      = (count == '0);
  assign head       = slots[rptr];
  assign free_slots = RES_CNT_W'(RES_DEPTH) - count;
  assign do_pop     = pop && !empty;

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      if (push_mask[k]) begin
        slots[wptr + off[k]] <= push_ent[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + n_push[RES_PTR_W-1:0];
      if (do_pop) begin
        rptr <= rptr + RES_PTR_W'(1);
      end
      count <= count + n_push - RES_CNT_W'(do_pop);
    end
  end

endmodule

// ===== src/neighbour_equality_map_unit.sv =====
// top level of the 3x3 neighbour equality map
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  pixels   | push / full             | pixel_value
//  results  | pop / empty             | match_flag, result_row, result_col, frame_done
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one pixel request is taken every cycle while the results are drained; the first
// result of a pixel appears after it passes the task queue, s1, s2 and the result buffer.
// a pixel causes up to four results, so the result side (one a cycle) sets the rate
// during the last row of a frame, where pixels may then wait on full
// rst clears counters, queues and geometry (8 x 8); the line store is not cleared,
// its stale entries only ever stand for neighbours outside the frame
module neighbour_equality_map_unit #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [nem_pkg::IN_PIX_W-1:0]     pixel_value,
  output logic                             empty,
  input  logic                             pop,
  output logic                             match_flag,
  output logic [nem_pkg::ROW_W-1:0]        result_row,
  output logic [nem_pkg::RES_COL_W-1:0]    result_col,
  output logic                             frame_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nem_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nem_pkg::*;

  // only the low pixel bits take part in the comparison
  localparam int PIX_W  = (PIXEL_BITS < IN_PIX_W) ? PIXEL_BITS : IN_PIX_W;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int TASK_W = PIX_W + COL_W + ROW_W + FLAGS_W;

  logic                     accept;
  logic [COL_W-1:0]         f_col;
  logic [ROW_W-1:0]         f_row;
  nem_flags_t               f_flags;
  logic [TASK_W-1:0]        q_wdata;
  logic                     q_valid;
  logic [TASK_W-1:0]        q_rdata;
  logic                     q_take;
  logic [RES_CNT_W-1:0]     free_slots;
  logic [RES_PER_ITEM-1:0]  res_mask;
  nem_result_t              res_ent [RES_PER_ITEM];
  nem_result_t              head;

  assign accept = push && !full;

  // front: geometry, position counters, border classification
  nem_front #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .t_col     (f_col),
    .t_row     (f_row),
    .t_flags   (f_flags)
  );

  assign q_wdata = {pixel_value[PIX_W-1:0], f_col, f_row, f_flags};

  // decoupling queue, full here is the pixel side's full
  nem_fifo #(
    .WIDTH (TASK_W),
    .DEPTH (TASK_DEPTH)
  ) u_task_q (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (q_wdata),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  // back: line store read, window shift, comparisons
  nem_back #(
    .PIX_W     (PIX_W),
    .COL_W     (COL_W),
    .MEM_DEPTH (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .task_valid (q_valid),
    .task_data  (q_rdata),
    .task_take  (q_take),
    .free_slots (free_slots),
    .res_mask   (res_mask),
    .res_ent    (res_ent)
  );

  // result queue absorbs the bursts at the end of rows and frames
  nem_result_buf u_res_buf (
    .clk        (clk),
    .rst        (rst),
    .push_mask  (res_mask),
    .push_ent   (res_ent),
    .pop        (pop),
    .empty      (empty),
    .head       (head),
    .free_slots (free_slots)
  );

  assign match_flag = head.match_flag;
  assign result_row = head.row;
  assign result_col = head.col;
  assign frame_done = head.frame_done;

endmodule
